[design/ptss_pkg.sv]
// package for the periodic task slot scheduler
// request, action and status codes plus default sizes; no dependencies
package ptss_pkg;

    localparam int unsigned MAX_TASKS_DEF      = 16;
    localparam int unsigned MAX_GENERATION_DEF = 32767;
    localparam logic [31:0] DEFAULT_YIELD_RST  = 32'd1;
    localparam logic [31:0] HALF_RANGE         = 32'h8000_0000;

    localparam logic [2:0] REQ_START  = 3'd0;
    localparam logic [2:0] REQ_CANCEL = 3'd1;
    localparam logic [2:0] REQ_CLEAR  = 3'd2;
    localparam logic [2:0] REQ_POLL   = 3'd3;
    localparam logic [2:0] REQ_REPORT = 3'd4;
    localparam logic [2:0] REQ_QUERY  = 3'd5;

    localparam logic [1:0] ACT_DONE    = 2'd0;
    localparam logic [1:0] ACT_YIELD   = 2'd1;
    localparam logic [1:0] ACT_SLEEP   = 2'd2;
    localparam logic [1:0] ACT_INVALID = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;

endpackage

[design/periodic_task_slot_scheduler.sv]
// periodic task slot scheduler: slot table with generation-checked handles
// depends on ptss_pkg; one module with a shared scan-pointer datapath and a serial divider
//
//  channel | signals                                   | direction | flow
//  --------+-------------------------------------------+-----------+----------------------
//  request | start, busy, req_type..sleep_ms           | in        | taken on start & !busy
//  result  | result_valid, status..task_count          | out       | one-cycle strobe
//  config  | cfg_valid, cfg_ready, cfg_data            | in        | taken on valid & ready
//
// a request walks the table one slot per cycle; start, poll, query and clear scan in S_SCAN,
// cancel is settled in S_CHECK, and a report on a periodic task also runs the restoring
// divider in S_DIV and then S_BND before S_DONE
// reset clears every slot at once (valid bits in flip-flops), cursors to zero, delay to one
// the result strobe cannot be held off; busy drops in the cycle the strobe is shown
module periodic_task_slot_scheduler
    import ptss_pkg::*;
#(
    parameter int unsigned MAX_TASKS      = MAX_TASKS_DEF,
    parameter int unsigned MAX_GENERATION = MAX_GENERATION_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [31:0] now_ms,
    input  logic [31:0] first_delay_ms,
    input  logic [31:0] interval_ms,
    input  logic [30:0] handle,
    input  logic [1:0]  action_code,
    input  logic [31:0] sleep_ms,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [30:0] handle_out,
    output logic [31:0] due_ms,
    output logic        has_tasks,
    output logic [4:0]  task_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CHECK, S_DIV, S_BND, S_DONE
    } state_t;

    state_t state_reg;

    logic [MAX_TASKS-1:0] occ_reg;
    logic [31:0]          next_run_mem [MAX_TASKS];
    logic [31:0]          period_mem   [MAX_TASKS];
    logic [14:0]          gen_mem      [MAX_TASKS];
    logic [CW-1:0]        count_reg;
    logic [IW-1:0]        alloc_reg;
    logic [IW-1:0]        run_reg;
    logic [31:0]          yield_reg;

    logic [2:0]  req_reg;
    logic [31:0] now_reg, after_reg, per_in_reg, arg_reg;
    logic [1:0]  act_reg;
    logic [IW-1:0] idx_reg;
    logic [CW-1:0] step_reg;
    logic        found_reg;
    logic [31:0] best_w_reg;

    // divider state: quotient in q, remainder in r
    logic [31:0] q_reg, r_reg, dvs_reg, prev_reg;
    logic [5:0]  dcnt_reg;

    logic [1:0]  status_reg;
    logic [30:0] hout_reg;
    logic [31:0] due_reg;
    logic        rv_reg;

    // handle decode
    logic [15:0] h_part;
    logic [14:0] h_gen;
    logic        h_ok;
    logic [IW-1:0] h_idx;
    always_comb
    begin
        h_part = handle[15:0];
        h_gen  = handle[30:16];
        h_idx  = IW'(h_part - 16'd1);
        h_ok   = (h_part != 16'd0) && (32'(h_part) <= MAX_TASKS) && (h_gen != 15'd0)
                 && occ_reg[h_idx] && (gen_mem[h_idx] == h_gen);
    end

    function automatic logic [14:0] gen_adv(input logic [14:0] g);
        logic [15:0] n;
        n = {1'b0, g} + 16'd1;
        if (n == 16'd0 || 32'(n) > MAX_GENERATION)
            n = 16'd1;
        return n[14:0];
    endfunction

    function automatic logic [30:0] mk_handle(input logic [IW-1:0] i, input logic [14:0] g);
        if (g == 15'd0 || 32'(g) > MAX_GENERATION)
            return '0;
        return {g, 16'(32'(i) + 1)};
    endfunction

    // shared datapath values for the slot under the scan pointer
    logic [31:0] cur_nr, cur_diff, wait_v, dsum, sd_v, rtrial;
    logic        cur_reached;
    always_comb
    begin
        cur_nr      = next_run_mem[idx_reg];
        cur_diff    = now_reg - cur_nr;
        cur_reached = cur_diff < HALF_RANGE;
        wait_v      = cur_reached ? 32'd0 : (cur_nr - now_reg);
        sd_v        = now_reg + ((arg_reg == 32'd0) ? yield_reg : arg_reg);
        rtrial      = {r_reg[30:0], q_reg[31]};
        dsum        = prev_reg + (q_reg + 32'd1) * dvs_reg;
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign result_valid = rv_reg;
    assign status    = status_reg;
    assign handle_out = hout_reg;
    assign due_ms    = due_reg;
    assign has_tasks = (count_reg != '0);
    assign task_count = 5'(count_reg);

    logic [IW-1:0] wrap_next;
    assign wrap_next = (32'(idx_reg) == MAX_TASKS - 1) ? '0 : idx_reg + IW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            count_reg  <= '0;
            alloc_reg  <= '0;
            run_reg    <= '0;
            yield_reg  <= DEFAULT_YIELD_RST;
            rv_reg     <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++)
                gen_mem[i] <= '0;
        end
        else
        begin
            rv_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                        yield_reg <= cfg_data;
                    if (start)
                    begin
                        req_reg    <= req_type;
                        now_reg    <= now_ms;
                        after_reg  <= first_delay_ms;
                        per_in_reg <= interval_ms;
                        act_reg    <= action_code;
                        arg_reg    <= sleep_ms;
                        step_reg   <= '0;
                        found_reg  <= 1'b0;
                        status_reg <= ST_OK;
                        hout_reg   <= '0;
                        due_reg    <= '0;
                        case (req_type)
                            REQ_START:            idx_reg <= alloc_reg;
                            REQ_POLL:             idx_reg <= run_reg;
                            REQ_CLEAR, REQ_QUERY: idx_reg <= '0;
                            default:              idx_reg <= h_idx;
                        endcase
                        case (req_type)
                            REQ_CANCEL, REQ_REPORT:
                            begin
                                if (!h_ok)
                                begin
                                    status_reg <= ST_STALE;
                                    state_reg  <= S_DONE;
                                end
                                else
                                    state_reg <= S_CHECK;
                            end
                            REQ_CLEAR, REQ_QUERY:
                            begin
                                state_reg <= S_SCAN;
                            end
                            REQ_START:
                            begin
                                if (32'(count_reg) >= MAX_TASKS)
                                begin
                                    status_reg <= ST_NONE;
                                    state_reg  <= S_DONE;
                                end
                                else
                                    state_reg <= S_SCAN;
                            end
                            REQ_POLL:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= ST_NONE;
                                    state_reg  <= S_DONE;
                                end
                                else
                                    state_reg <= S_SCAN;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    // one slot per cycle
                    step_reg <= step_reg + CW'(1);
                    idx_reg  <= wrap_next;
                    case (req_reg)
                        REQ_START:
                        begin
                            if (!occ_reg[idx_reg])
                            begin
                                occ_reg[idx_reg]      <= 1'b1;
                                next_run_mem[idx_reg] <= now_reg + after_reg;
                                period_mem[idx_reg]   <= per_in_reg;
                                if (gen_mem[idx_reg] == 15'd0
                                    || 32'(gen_mem[idx_reg]) > MAX_GENERATION)
                                begin
                                    gen_mem[idx_reg] <= 15'd1;
                                    hout_reg <= mk_handle(idx_reg, 15'd1);
                                end
                                else
                                    hout_reg <= mk_handle(idx_reg, gen_mem[idx_reg]);
                                count_reg <= count_reg + CW'(1);
                                alloc_reg <= wrap_next;
                                state_reg <= S_DONE;
                            end
                        end
                        REQ_POLL:
                        begin
                            if (occ_reg[idx_reg] && cur_reached)
                            begin
                                run_reg   <= wrap_next;
                                hout_reg  <= mk_handle(idx_reg, gen_mem[idx_reg]);
                                state_reg <= S_DONE;
                            end
                            else if (32'(step_reg) == MAX_TASKS - 1)
                            begin
                                status_reg <= ST_NONE;
                                state_reg  <= S_DONE;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            if (occ_reg[idx_reg])
                            begin
                                occ_reg[idx_reg]      <= 1'b0;
                                next_run_mem[idx_reg] <= '0;
                                period_mem[idx_reg]   <= '0;
                                gen_mem[idx_reg]      <= gen_adv(gen_mem[idx_reg]);
                                count_reg             <= count_reg - CW'(1);
                            end
                            if (32'(step_reg) == MAX_TASKS - 1)
                            begin
                                run_reg   <= '0;
                                alloc_reg <= '0;
                                state_reg <= S_DONE;
                            end
                        end
                        default:
                        begin
                            // query: least wait, first in index order on ties
                            if (occ_reg[idx_reg] && (!found_reg || wait_v < best_w_reg))
                            begin
                                found_reg    <= 1'b1;
                                best_w_reg   <= wait_v;
                                due_reg      <= cur_nr;
                            end
                            if (32'(step_reg) == MAX_TASKS - 1)
                            begin
                                if (!found_reg && !occ_reg[idx_reg])
                                    status_reg <= ST_NONE;
                                state_reg <= S_DONE;
                            end
                        end
                    endcase
                end
                S_CHECK:
                begin
                    prev_reg <= cur_nr;
                    dvs_reg  <= period_mem[idx_reg];
                    q_reg    <= cur_diff;
                    r_reg    <= '0;
                    dcnt_reg <= '0;
                    if (req_reg == REQ_CANCEL || act_reg == ACT_DONE
                        || act_reg == ACT_INVALID)
                    begin
                        occ_reg[idx_reg]      <= 1'b0;
                        next_run_mem[idx_reg] <= '0;
                        period_mem[idx_reg]   <= '0;
                        gen_mem[idx_reg]      <= gen_adv(gen_mem[idx_reg]);
                        count_reg             <= count_reg - CW'(1);
                        state_reg             <= S_DONE;
                    end
                    else if (period_mem[idx_reg] == 32'd0)
                    begin
                        next_run_mem[idx_reg] <= (act_reg == ACT_YIELD)
                                                 ? now_reg + yield_reg : sd_v;
                        state_reg <= S_DONE;
                    end
                    else if (!cur_reached)
                    begin
                        // boundary keeps the stored time, unless a sleep ends at or after it
                        if (act_reg == ACT_SLEEP && (sd_v - cur_nr) < HALF_RANGE)
                            next_run_mem[idx_reg] <= sd_v;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    if (rtrial >= dvs_reg)
                    begin
                        r_reg <= rtrial - dvs_reg;
                        q_reg <= {q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= rtrial;
                        q_reg <= {q_reg[30:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd31)
                        state_reg <= S_BND;
                end
                S_BND:
                begin
                    if (act_reg == ACT_SLEEP && (sd_v - dsum) < HALF_RANGE)
                        next_run_mem[idx_reg] <= sd_v;
                    else
                        next_run_mem[idx_reg] <= dsum;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    rv_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a result strobe always ends a request
    assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> !busy) else $error("result while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_reg) == 32'(count_reg)) else $error("count mismatch");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && req_reg == REQ_START && status_reg == ST_OK) |-> (hout_reg != '0))
        else $error("start gave null handle");

endmodule
